@@ rtl/tcprtt_pkg.sv @@
`timescale 1ns / 1ps

package tcprtt_pkg;

    // Table geometry default
    localparam int unsigned TABLE_DEPTH_DEF = 64;

    // Header decode constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam int unsigned FLAG_SYN_BIT   = 1;
    localparam int unsigned FLAG_ACK_BIT   = 4;

    // Register reset value
    localparam logic [15:0] MAX_MATCHES_RST = 16'd1000;

    // Time conversion: usec/1000 by reciprocal multiply, exact for |du| < 2^20
    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned USEC_PER_MS  = 1000;
    localparam int unsigned USEC_W       = 20;
    localparam int unsigned RECIP_SHIFT  = 30;
    localparam int unsigned RECIP_W      = 21;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + USEC_PER_MS - 1) / USEC_PER_MS);

    // Result status codes
    typedef enum logic [2:0] {
        ST_NOT_TCP       = 3'd0,
        ST_SYN_STORED    = 3'd1,
        ST_SYN_DROPPED   = 3'd2,
        ST_MATCHED       = 3'd3,
        ST_ACK_UNMATCHED = 3'd4,
        ST_OTHER         = 3'd5,
        ST_LIMIT         = 3'd6
    } t_status;

    // Input beat
    typedef struct packed {
        logic [15:0]       eth_type;
        logic [7:0]        ip_protocol;
        logic [7:0]        tcp_flags;
        logic [31:0]       seq_num;
        logic [31:0]       ack_num;
        logic [31:0]       ts_sec;
        logic [USEC_W-1:0] ts_usec;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] rtt_ms;
        logic signed [63:0] sum_ms;
        logic [15:0]        match_count;
    } t_out_beat;

    // One table entry as held in memory
    typedef struct packed {
        logic              valid;
        logic [31:0]       seq;
        logic [31:0]       sec;
        logic [USEC_W-1:0] usec;
    } t_entry;

endpackage

@@ rtl/tcprtt_rtt.sv @@
`timescale 1ns / 1ps

// Three-stage RTT unit: rtt = (dsec * 1000) + trunc(dusec / 1000), 32-bit wrap
module tcprtt_rtt import tcprtt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_ts_sec,
    input  logic [USEC_W-1:0] i_ts_usec,
    input  logic [31:0]       i_ent_sec,
    input  logic [USEC_W-1:0] i_ent_usec,
    output logic              o_done,
    output logic [31:0]       o_rtt
);

    localparam int unsigned PROD_W = USEC_W + RECIP_W;
    localparam int unsigned Q_W    = PROD_W - RECIP_SHIFT;

    logic [USEC_W:0]     n_du;
    logic [PROD_W-1:0]   n_prod;
    logic [31:0]         n_q;

    logic                r_v1, r_v2, r_v3;
    logic                r_neg1, r_neg2;
    logic [USEC_W-1:0]   r_abs;
    logic [31:0]         r_dsec;
    logic [Q_W-1:0]      r_qabs;
    logic [31:0]         r_ms;
    logic [31:0]         r_rtt;

    // Signed usec difference, one bit wider than the field
    assign n_du   = {1'b0, i_ts_usec} - {1'b0, i_ent_usec};
    assign n_prod = PROD_W'(r_abs) * PROD_W'(DIV_RECIP);
    assign n_q    = 32'(r_qabs);

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        // stage 1: differences, magnitude of usec delta
        r_neg1 <= n_du[USEC_W];
        r_abs  <= n_du[USEC_W] ? USEC_W'(-n_du) : n_du[USEC_W-1:0];
        r_dsec <= i_ts_sec - i_ent_sec;
        // stage 2: both multiplies
        r_qabs <= n_prod[PROD_W-1:RECIP_SHIFT];
        r_ms   <= r_dsec * 32'(MS_PER_SEC);
        r_neg2 <= r_neg1;
        // stage 3: quotient truncates toward zero
        r_rtt  <= r_ms + (r_neg2 ? -n_q : n_q);
    end

    assign o_done = r_v3;
    assign o_rtt  = r_rtt;

endmodule

@@ rtl/tcp_syn_ack_rtt_tracker_core.sv @@
`timescale 1ns / 1ps

// Channel  Beat        Valid         Stall          Accepted when
// ------   ----------  ------------  -------------  ---------------------------
// in       i_in        i_in_valid    o_in_stall     i_in_valid && !o_in_stall
// out      o_out       o_out_valid   i_out_stall    o_out_valid && !i_out_stall
// cfg      i_cfg_wdata i_cfg_we      -              i_cfg_we (max_matches)
//
// One header at a time. Non-TCP, limit and other-TCP headers skip the table scan.
// SYN and ACK headers scan the whole table through its single read port, one
// entry per cycle; a match then waits in S_CALC for the RTT multiplies.
// After reset a clearing pass over every table entry holds o_in_stall high.
// A stalled output holds one finished result; the next result waits in S_OUT.
module tcp_syn_ack_rtt_tracker_core import tcprtt_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_SCAN, S_ACT, S_CALC, S_OUT
    } t_state;

    t_state           r_state;
    t_in_beat         r_item;
    t_status          r_res_status;
    logic [31:0]      r_res_rtt;
    logic [31:0]      r_key;
    logic             r_is_syn;
    logic [15:0]      r_max;
    logic [63:0]      r_sum;
    logic [15:0]      r_total;
    logic             r_out_valid;
    t_out_beat        r_out;

    // scan pipeline
    logic [AW-1:0]    r_rd_addr;
    logic             r_issue;
    logic             r_cmp_vld;
    logic [AW-1:0]    r_cmp_addr;
    t_entry           r_rd_data;
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic [31:0]      r_hit_sec;
    logic [USEC_W-1:0] r_hit_usec;
    logic             r_free;
    logic [AW-1:0]    r_free_idx;

    // table memory
    t_entry           r_mem [TABLE_DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;

    logic             key_hit;
    logic             out_free;
    logic             calc_start;
    logic             calc_done;
    logic [31:0]      calc_rtt;

    assign key_hit    = r_rd_data.valid && (r_rd_data.seq == r_key);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign calc_start = (r_state == S_ACT) && !r_is_syn && r_hit;

    // RTT arithmetic
    tcprtt_rtt u_rtt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (calc_start),
        .i_ts_sec   (r_item.ts_sec),
        .i_ts_usec  (r_item.ts_usec),
        .i_ent_sec  (r_hit_sec),
        .i_ent_usec (r_hit_usec),
        .o_done     (calc_done),
        .o_rtt      (calc_rtt)
    );

    // Table write port: clear sweep, SYN store, match invalidate
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_addr;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_ACT: begin
                if (r_is_syn && (r_hit || r_free)) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_hit ? r_hit_idx : r_free_idx;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.seq   = r_key;
                    mem_wdata.sec   = r_item.ts_sec;
                    mem_wdata.usec  = r_item.ts_usec;
                end
            end
            S_CALC: begin
                if (calc_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hit_idx;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_MATCHES_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // Control FSM, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rd_addr   <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_sum       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat: load a new result or retire the shown one
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_rd_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_rtt <= '0;
                    r_rd_addr <= '0;
                    r_issue   <= 1'b1;
                    r_cmp_vld <= 1'b0;
                    r_hit     <= 1'b0;
                    r_free    <= 1'b0;
                    if (r_total >= r_max) begin
                        r_res_status <= ST_LIMIT;
                        r_state      <= S_OUT;
                    end else if (r_item.eth_type != ETHERTYPE_IPV4 ||
                                 r_item.ip_protocol != PROTO_TCP) begin
                        r_res_status <= ST_NOT_TCP;
                        r_state      <= S_OUT;
                    end else if (r_item.tcp_flags[FLAG_SYN_BIT]) begin
                        r_is_syn <= 1'b1;
                        r_key    <= r_item.seq_num;
                        r_state  <= S_SCAN;
                    end else if (r_item.tcp_flags[FLAG_ACK_BIT]) begin
                        r_is_syn <= 1'b0;
                        r_key    <= r_item.ack_num - 32'd1;
                        r_state  <= S_SCAN;
                    end else begin
                        r_res_status <= ST_OTHER;
                        r_state      <= S_OUT;
                    end
                end
                S_SCAN: begin
                    // issue side
                    r_cmp_vld  <= r_issue;
                    r_cmp_addr <= r_rd_addr;
                    if (r_issue) begin
                        if (r_rd_addr == LAST_ADDR) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_addr <= r_rd_addr + 1'b1;
                        end
                    end
                    // compare side: keep first key hit and first free slot
                    if (r_cmp_vld) begin
                        if (key_hit && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_cmp_addr;
                            r_hit_sec  <= r_rd_data.sec;
                            r_hit_usec <= r_rd_data.usec;
                        end
                        if (!r_rd_data.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_cmp_addr;
                        end
                        if (r_cmp_addr == LAST_ADDR) begin
                            r_state <= S_ACT;
                        end
                    end
                end
                S_ACT: begin
                    if (r_is_syn) begin
                        r_res_status <= (r_hit || r_free) ? ST_SYN_STORED : ST_SYN_DROPPED;
                        r_state      <= S_OUT;
                    end else if (r_hit) begin
                        r_state <= S_CALC;
                    end else begin
                        r_res_status <= ST_ACK_UNMATCHED;
                        r_state      <= S_OUT;
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        r_res_status <= ST_MATCHED;
                        r_res_rtt    <= calc_rtt;
                        r_sum        <= r_sum + {{32{calc_rtt[31]}}, calc_rtt};
                        r_total      <= r_total + 16'd1;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.status      <= r_res_status;
                        r_out.rtt_ms      <= r_res_rtt;
                        r_out.sum_ms      <= r_sum;
                        r_out.match_count <= r_total;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // Match count moves only on a finished RTT calculation
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_total != $past(r_total)))
            |-> ($past(r_state) == S_CALC && $past(calc_done)))
        else $error("match count changed outside a match");

    // RTT unit only finishes while the FSM waits for it
    a_calc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_done |-> (r_state == S_CALC))
        else $error("rtt result arrived outside S_CALC");

    // No table write while a scan is reading it
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("table written during scan");

    // A shown result carries rtt only when matched
    a_rtt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_MATCHED)) |-> (r_out.rtt_ms == 32'sd0))
        else $error("nonzero rtt on unmatched result");
`endif

endmodule

@@ verif/tb_tcp_syn_ack_rtt_tracker_core.sv @@
`timescale 1ns / 1ps

module tb_tcp_syn_ack_rtt_tracker_core;
    import tcprtt_pkg::*;

    localparam int TBL_DEPTH        = TABLE_DEPTH_DEF;
    localparam int BLOCK_ITEMS      = 159;
    localparam int BLOCKS_PER_PHASE = 3;
    localparam int SETTLE_CYCLES    = 2 * TBL_DEPTH + 16;
    localparam int WATCHDOG_CYCLES  = 5000;
    localparam logic [7:0] SYN_MASK = 8'(1 << FLAG_SYN_BIT);
    localparam logic [7:0] ACK_MASK = 8'(1 << FLAG_ACK_BIT);

    // DUT connections
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_beat    in_beat   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_beat   out_beat;

    // Handshake tracker state: shadow flow table and totals
    bit                tbl_valid [TBL_DEPTH];
    logic [31:0]       tbl_seq   [TBL_DEPTH];
    logic [31:0]       tbl_sec   [TBL_DEPTH];
    logic [USEC_W-1:0] tbl_usec  [TBL_DEPTH];
    logic signed [63:0] rtt_total   = '0;
    logic [15:0]        matched_cnt = '0;
    logic [15:0]        match_limit = MAX_MATCHES_RST;

    t_out_beat pending_results [$];
    int        mismatch_cnt   = 0;
    int        idle_cycles    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        block_no       = 0;

    tcp_syn_ack_rtt_tracker_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatch_cnt++;
    endtask

    function automatic int find_seq(input logic [31:0] key);
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_seq[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Advance the shadow tracker by one header and return the result it gives
    function automatic t_out_beat track_header(input t_in_beat hdr);
        int          slot;
        int          du;
        int          q;
        logic [31:0] ms;
        logic [31:0] rtt;
        t_out_beat   res;
        rtt = '0;
        res = '0;
        if (matched_cnt >= match_limit) begin
            res.status = ST_LIMIT;
        end else if (hdr.eth_type != ETHERTYPE_IPV4 || hdr.ip_protocol != PROTO_TCP) begin
            res.status = ST_NOT_TCP;
        end else if (hdr.tcp_flags[FLAG_SYN_BIT]) begin
            // same key overwrites, else lowest free slot
            slot = find_seq(hdr.seq_num);
            if (slot < 0) begin
                for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
                    if (!tbl_valid[i]) slot = i;
                end
            end
            if (slot < 0) begin
                res.status = ST_SYN_DROPPED;
            end else begin
                tbl_valid[slot] = 1'b1;
                tbl_seq[slot]   = hdr.seq_num;
                tbl_sec[slot]   = hdr.ts_sec;
                tbl_usec[slot]  = hdr.ts_usec;
                res.status      = ST_SYN_STORED;
            end
        end else if (hdr.tcp_flags[FLAG_ACK_BIT]) begin
            slot = find_seq(hdr.ack_num - 32'd1);
            if (slot < 0) begin
                res.status = ST_ACK_UNMATCHED;
            end else begin
                // 32-bit wrapping ms, usec delta divided toward zero
                du  = int'(hdr.ts_usec) - int'(tbl_usec[slot]);
                q   = du / int'(USEC_PER_MS);
                ms  = (hdr.ts_sec - tbl_sec[slot]) * 32'(MS_PER_SEC);
                rtt = ms + 32'(q);
                tbl_valid[slot] = 1'b0;
                rtt_total   = rtt_total + {{32{rtt[31]}}, rtt};
                matched_cnt = matched_cnt + 16'd1;
                res.status  = ST_MATCHED;
            end
        end else begin
            res.status = ST_OTHER;
        end
        res.rtt_ms      = rtt;
        res.sum_ms      = rtt_total;
        res.match_count = matched_cnt;
        return res;
    endfunction

    function automatic t_in_beat tcp_header(input logic [7:0] flags, input logic [31:0] seq,
                                            input logic [31:0] ack, input logic [31:0] sec,
                                            input logic [USEC_W-1:0] usec);
        t_in_beat hdr;
        hdr.eth_type    = ETHERTYPE_IPV4;
        hdr.ip_protocol = PROTO_TCP;
        hdr.tcp_flags   = flags;
        hdr.seq_num     = seq;
        hdr.ack_num     = ack;
        hdr.ts_sec      = sec;
        hdr.ts_usec     = usec;
        return hdr;
    endfunction

    // Drive one header beat, hold it until taken, then log its expected result
    task automatic send_header(input t_in_beat hdr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= hdr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.insert(pending_results.size(), track_header(hdr));
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_matches(input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we      <= 1'b0;
        match_limit = val;
    endtask

    // Non-IPv4, non-TCP and flagless headers
    task automatic test_header_filters();
        t_in_beat hdr;
        hdr = tcp_header(SYN_MASK, 32'h1, 32'h0, 32'h5, 20'd7);
        hdr.eth_type = 16'hFFFF;
        send_header(hdr);
        hdr = tcp_header(SYN_MASK, 32'h2, 32'h0, 32'h5, 20'd7);
        hdr.ip_protocol = 8'hFF;
        send_header(hdr);
        send_header('0);
        send_header(tcp_header(8'h00, 32'h0, 32'h0, 32'h0, 20'd0));
        send_header(tcp_header(8'hFF & ~(SYN_MASK | ACK_MASK), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 20'hFFFFF));
    endtask

    // SYN/ACK pairs: key wrap, repeats, SYN+ACK, negative and wrapping rtt
    task automatic test_handshake_cases();
        send_header(tcp_header(SYN_MASK, 32'hFFFF_FFFF, 32'h0, 32'd10, 20'd999999));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'h0, 32'd11, 20'd0));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'h0, 32'd11, 20'd0));
        send_header(tcp_header(8'hFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 20'hFFFFF));
        send_header(tcp_header(SYN_MASK, 32'h0, 32'h0, 32'h0, 20'hFFFFF));
        send_header(tcp_header(8'hFD, 32'h0, 32'h1, 32'hFFFF_FFFF, 20'd0));
        send_header(tcp_header(SYN_MASK, 32'h1234_5678, 32'h0, 32'h0, 20'd0));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'h1234_5679, 32'h0050_0000, 20'd0));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'hDEAD_BEEF, 32'd3, 20'd3));
        send_header(tcp_header(SYN_MASK | ACK_MASK, 32'hA5A5_A5A5, 32'h0, 32'd40, 20'd0));
        send_header(tcp_header(SYN_MASK | ACK_MASK, 32'h5A5A_5A5A, 32'hA5A5_A5A6, 32'd40,
                               20'd0));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'hA5A5_A5A6, 32'd40, 20'd999999));
    endtask

    // Limit just above the current count, then zero, then the widest setting
    task automatic test_match_limit();
        wait_idle();
        write_max_matches(matched_cnt + 16'd1);
        send_header(tcp_header(SYN_MASK, 32'h0BAD_F00D, 32'h0, 32'd100, 20'd500));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'h0BAD_F00E, 32'd101, 20'd400));
        send_header(tcp_header(SYN_MASK, 32'h0000_0077, 32'h0, 32'd102, 20'd0));
        send_header(tcp_header(ACK_MASK, 32'h0, 32'h0000_5A5B, 32'd102, 20'd0));
        wait_idle();
        write_max_matches(16'd0);
        send_header(tcp_header(SYN_MASK, 32'h0000_0088, 32'h0, 32'd103, 20'd0));
        wait_idle();
        write_max_matches(16'hFFFF);
    endtask

    // Alternating fill and drain blocks of mostly well-formed handshakes
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
        t_in_beat hdr;
        int       roll;
        int       slot;
        int       n_open;
        int       syn_w;
        int       ack_w;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        repeat (BLOCKS_PER_PHASE) begin
            syn_w = (block_no % 2 == 0) ? 58 : 14;
            ack_w = (block_no % 2 == 0) ? 14 : 58;
            repeat (BLOCK_ITEMS) begin
                // pick a live entry at random to aim repeats and ACKs at
                slot   = -1;
                n_open = 0;
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        n_open++;
                        if ($urandom_range(n_open - 1) == 0) slot = i;
                    end
                end
                hdr = tcp_header(8'($urandom), $urandom, $urandom, $urandom,
                                 ($urandom_range(15) == 0) ? 20'($urandom)
                                                           : 20'($urandom_range(999999)));
                roll = $urandom_range(99);
                if (roll < 8) begin
                    case ($urandom_range(2))
                        0: hdr.eth_type = 16'($urandom);
                        1: hdr.ip_protocol = 8'($urandom);
                        default: begin
                            hdr.eth_type    = 16'($urandom);
                            hdr.ip_protocol = 8'($urandom);
                        end
                    endcase
                end else if (roll < 12) begin
                    hdr.tcp_flags[FLAG_SYN_BIT] = 1'b0;
                    hdr.tcp_flags[FLAG_ACK_BIT] = 1'b0;
                end else if (roll < 12 + syn_w) begin
                    hdr.tcp_flags[FLAG_SYN_BIT] = 1'b1;
                end else if (roll < 18 + syn_w) begin
                    hdr.tcp_flags[FLAG_SYN_BIT] = 1'b1;
                    if (slot >= 0) hdr.seq_num = tbl_seq[slot];
                end else begin
                    hdr.tcp_flags[FLAG_SYN_BIT] = 1'b0;
                    hdr.tcp_flags[FLAG_ACK_BIT] = 1'b1;
                    if (roll < 18 + syn_w + ack_w && slot >= 0) begin
                        hdr.ack_num = tbl_seq[slot] + 32'd1;
                        if ($urandom_range(7) != 0) begin
                            hdr.ts_sec = tbl_sec[slot] + 32'($urandom_range(3));
                        end
                    end
                end
                send_header(hdr);
            end
            block_no++;
        end
    endtask

    // Receiver: random stall, check each accepted result beat
    always @(posedge clk) begin : out_check
        t_out_beat want;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(out_beat.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (out_beat.status !== want.status)
                    report_mismatch("status", 64'(out_beat.status), 64'(want.status));
                if (out_beat.rtt_ms !== want.rtt_ms)
                    report_mismatch("rtt_ms", 64'(out_beat.rtt_ms), 64'(want.rtt_ms));
                if (out_beat.sum_ms !== want.sum_ms)
                    report_mismatch("sum_ms", out_beat.sum_ms, want.sum_ms);
                if (out_beat.match_count !== want.match_count)
                    report_mismatch("match_count", 64'(out_beat.match_count),
                                    64'(want.match_count));
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        send_idle_pct  = 36;
        recv_stall_pct = 83;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_header_filters();
        test_handshake_cases();
        test_match_limit();
        test_random_traffic(36, 83);
        wait_idle();
        write_max_matches(MAX_MATCHES_RST);
        test_random_traffic(83, 36);
        wait_idle();
        write_max_matches(16'hFFFF);
        test_random_traffic(0, 0);
        wait_idle();
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
